### src/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths, register codes, reset values and divider status type for the
// sprite screen projection block.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // Field widths
    localparam int POS_W    = 32;   // Q16.16 positions
    localparam int VEC_W    = 16;   // Q2.14 direction and plane
    localparam int RES_W    = 12;   // screen size
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Quotient bits produced by every divider
    localparam int QUO_W    = 32;

    // Divider operand widths
    localparam int DEPTH_NUM_W  = 64;   // |ty| << 14
    localparam int DEPTH_DEN_W  = 32;   // |det|
    localparam int CENTER_NUM_W = 63;   // |half_w * (tx + ty)|
    localparam int TY_ABS_W     = 50;   // |ty|
    localparam int SIZE_NUM_W   = 46;   // h * |det| * 4

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H     = 3'd7;

    // Reset values
    localparam logic [VEC_W-1:0] RST_DIR_X   = 16'd16384;
    localparam logic [VEC_W-1:0] RST_DIR_Y   = 16'd0;
    localparam logic [VEC_W-1:0] RST_PLANE_X = 16'd0;
    localparam logic [VEC_W-1:0] RST_PLANE_Y = 16'd10813;
    localparam logic [RES_W-1:0] RST_SCREEN_W = 12'd640;
    localparam logic [RES_W-1:0] RST_SCREEN_H = 12'd480;

    // Status carried with each quotient
    typedef struct packed {
        logic ovf;    // quotient too large, or divisor zero
        logic neg;    // result sign
        logic zero;   // dividend zero
    } div_flags_t;

endpackage

### src/ssp_div.sv
// ----------------------------------------------------------------------------
// ssp_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with an
// overflow check against the quotient width in the first stage.
// ----------------------------------------------------------------------------
module ssp_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  logic                clk,
    input  logic [QW:0]         en,
    input  logic [NW-1:0]       num,
    input  logic [DW-1:0]       den,
    input  logic                neg_in,
    output logic [QW-1:0]       quo,
    output ssp_pkg::div_flags_t flags
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0]       rem_reg [0:QW];
    logic [QW-1:0]       sh_reg  [0:QW];
    logic [DW-1:0]       den_reg [0:QW];
    ssp_pkg::div_flags_t flg_reg [0:QW];

    logic [CW-1:0]       hi_ext;
    logic [CW-1:0]       den_ext;
    ssp_pkg::div_flags_t flg_next;

    // First stage: split dividend, detect quotient overflow
    assign hi_ext  = CW'(num[NW-1:QW]);
    assign den_ext = CW'(den);

    always_comb
    begin
        flg_next.ovf  = (hi_ext >= den_ext);
        flg_next.neg  = neg_in;
        flg_next.zero = (num == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= hi_ext[DW-1:0];
            sh_reg[0]  <= num[QW-1:0];
            den_reg[0] <= den;
            flg_reg[0] <= flg_next;
        end
    end

    // One trial subtraction per stage
    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        assign trial = {rem_reg[k-1], sh_reg[k-1][QW-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                sh_reg[k]  <= {sh_reg[k-1][QW-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                flg_reg[k] <= flg_reg[k-1];
            end
        end
    end

    assign quo   = flg_reg[QW].zero ? '0 : sh_reg[QW];
    assign flags = flg_reg[QW];

endmodule

### src/sprite_screen_projection.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection
// Projects a sprite world position onto the screen: depth, centre column,
// size and clamped draw rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries obj_x, obj_y in Q16.16.
//   Output channel (out_valid / out_stall) carries one result per input.
//   The user must write registers via cfg_we / cfg_index / cfg_data only
//   while idle, unenforced by the block; derived camera terms then settle.
// Throughput: one transfer per cycle unless stalled. Each stage holds a valid bit
//   and moves on whenever the stage after it is empty or moving, so bubbles close up.
// Pipeline: 41 register stages, set by three restoring dividers (one quotient
//   bit per stage) plus front-end multiply and back-end clamp stages.
// Stall: with out_stall high the output register holds its result; stages
//   behind it keep filling until the pipe is full, then in_stall rises.
// Reset: all valid bits clear, configuration registers return to their reset values.
// ----------------------------------------------------------------------------
module sprite_screen_projection (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] obj_x,
    input  logic signed [31:0] obj_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] depth,
    output logic               in_front,
    output logic signed [15:0] center_col,
    output logic [15:0]        size_px,
    output logic [11:0]        top_row,
    output logic [11:0]        bottom_row,
    output logic [11:0]        left_col,
    output logic signed [15:0] right_col
);

    localparam int QW        = ssp_pkg::QUO_W;
    localparam int DIV_FIRST = 6;
    localparam int DIV_LAST  = DIV_FIRST + QW;
    localparam int ST_F1     = DIV_LAST + 1;
    localparam int ST_OUT    = ST_F1 + 1;
    localparam int NST       = ST_OUT + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] cam_x_reg, cam_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, pl_x_reg, pl_y_reg;
    logic [11:0]        scr_w_reg, scr_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            dir_x_reg <= ssp_pkg::RST_DIR_X;
            dir_y_reg <= ssp_pkg::RST_DIR_Y;
            pl_x_reg  <= ssp_pkg::RST_PLANE_X;
            pl_y_reg  <= ssp_pkg::RST_PLANE_Y;
            scr_w_reg <= ssp_pkg::RST_SCREEN_W;
            scr_h_reg <= ssp_pkg::RST_SCREEN_H;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssp_pkg::REG_CAM_POS_X:    cam_x_reg <= cfg_data;
                ssp_pkg::REG_CAM_POS_Y:    cam_y_reg <= cfg_data;
                ssp_pkg::REG_VIEW_DIR_X:   dir_x_reg <= cfg_data[15:0];
                ssp_pkg::REG_VIEW_DIR_Y:   dir_y_reg <= cfg_data[15:0];
                ssp_pkg::REG_VIEW_PLANE_X: pl_x_reg  <= cfg_data[15:0];
                ssp_pkg::REG_VIEW_PLANE_Y: pl_y_reg  <= cfg_data[15:0];
                ssp_pkg::REG_SCREEN_W:     scr_w_reg <= cfg_data[11:0];
                ssp_pkg::REG_SCREEN_H:     scr_h_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic [10:0] half_w, half_h;
    assign half_w = scr_w_reg[11:1];
    assign half_h = scr_h_reg[11:1];

    // ------------------------------------------------------------------
    // Camera-derived terms: determinant and size dividend
    // ------------------------------------------------------------------
    logic signed [31:0] det_pa_reg, det_pb_reg;
    logic signed [32:0] det_reg;
    logic [31:0]        adet_reg;
    logic               det_neg_reg;
    logic [43:0]        hdet_next;
    logic [45:0]        size_num_reg;

    assign hdet_next = scr_h_reg * adet_reg;

    always_ff @(posedge clk)
    begin
        det_pa_reg   <= pl_x_reg * dir_y_reg;
        det_pb_reg   <= dir_x_reg * pl_y_reg;
        det_reg      <= det_pa_reg - det_pb_reg;
        det_neg_reg  <= det_reg[32];
        adet_reg     <= det_reg[32] ? 32'(-det_reg) : det_reg[31:0];
        size_num_reg <= {hdet_next, 2'b00};
    end

    // ------------------------------------------------------------------
    // Valid bits and stage advance chain
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;

    assign adv[NST-1] = !vld_reg[NST-1] || !out_stall;
    for (genvar i = 0; i < NST - 1; i++)
    begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Front end: offsets, products, camera-space coordinates
    // ------------------------------------------------------------------
    logic signed [32:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [48:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [49:0] tx_reg, ty2_reg, ty3_reg, ty4_reg;
    logic signed [50:0] sum_reg;
    logic signed [62:0] cprod_reg;
    logic signed [62:0] cprod_next;

    assign dx_next    = {obj_x[31], obj_x} - {cam_x_reg[31], cam_x_reg};
    assign dy_next    = {obj_y[31], obj_y} - {cam_y_reg[31], cam_y_reg};
    assign cprod_next = $signed({1'b0, half_w}) * sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (adv[1])
        begin
            pa_reg <= dir_y_reg * dx_reg;
            pb_reg <= dir_x_reg * dy_reg;
            pc_reg <= pl_x_reg * dy_reg;
            pd_reg <= pl_y_reg * dx_reg;
        end
        if (adv[2])
        begin
            tx_reg  <= pa_reg - pb_reg;
            ty2_reg <= pc_reg - pd_reg;
        end
        if (adv[3])
        begin
            sum_reg <= tx_reg + ty2_reg;
            ty3_reg <= ty2_reg;
        end
        if (adv[4])
        begin
            cprod_reg <= cprod_next;
            ty4_reg   <= ty3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider operands as magnitude and sign
    // ------------------------------------------------------------------
    logic [ssp_pkg::DEPTH_NUM_W-1:0]  d_num_reg;
    logic [ssp_pkg::CENTER_NUM_W-1:0] c_num_reg;
    logic [ssp_pkg::TY_ABS_W-1:0]     ty_abs_reg;
    logic [ssp_pkg::SIZE_NUM_W-1:0]   s_num_reg;
    logic [ssp_pkg::DEPTH_DEN_W-1:0]  d_den_reg;
    logic                             d_neg_reg, c_neg_reg;
    logic [ssp_pkg::TY_ABS_W-1:0]     ty_abs_next;
    logic [ssp_pkg::CENTER_NUM_W-1:0] c_abs_next;

    assign ty_abs_next = ty4_reg[49] ? 50'(-ty4_reg) : ty4_reg;
    assign c_abs_next  = cprod_reg[62] ? 63'(-cprod_reg) : cprod_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            ty_abs_reg <= ty_abs_next;
            d_num_reg  <= {ty_abs_next, 14'd0};
            d_den_reg  <= adet_reg;
            d_neg_reg  <= ty4_reg[49] ^ det_neg_reg;
            c_num_reg  <= c_abs_next;
            c_neg_reg  <= cprod_reg[62] ^ ty4_reg[49];
            s_num_reg  <= size_num_reg;
        end
    end

    // ------------------------------------------------------------------
    // Dividers
    // ------------------------------------------------------------------
    logic [QW-1:0]       d_quo, c_quo, s_quo;
    ssp_pkg::div_flags_t d_flg, c_flg, s_flg;

    ssp_div #(
        .NW (ssp_pkg::DEPTH_NUM_W),
        .DW (ssp_pkg::DEPTH_DEN_W),
        .QW (QW)
    ) u_div_depth (
        .clk    (clk),
        .en     (adv[DIV_LAST:DIV_FIRST]),
        .num    (d_num_reg),
        .den    (d_den_reg),
        .neg_in (d_neg_reg),
        .quo    (d_quo),
        .flags  (d_flg)
    );

    ssp_div #(
        .NW (ssp_pkg::CENTER_NUM_W),
        .DW (ssp_pkg::TY_ABS_W),
        .QW (QW)
    ) u_div_center (
        .clk    (clk),
        .en     (adv[DIV_LAST:DIV_FIRST]),
        .num    (c_num_reg),
        .den    (ty_abs_reg),
        .neg_in (c_neg_reg),
        .quo    (c_quo),
        .flags  (c_flg)
    );

    ssp_div #(
        .NW (ssp_pkg::SIZE_NUM_W),
        .DW (ssp_pkg::TY_ABS_W),
        .QW (QW)
    ) u_div_size (
        .clk    (clk),
        .en     (adv[DIV_LAST:DIV_FIRST]),
        .num    (s_num_reg),
        .den    (ty_abs_reg),
        .neg_in (1'b0),
        .quo    (s_quo),
        .flags  (s_flg)
    );

    // ------------------------------------------------------------------
    // Saturation of quotients
    // ------------------------------------------------------------------
    logic signed [31:0] depth_next, depth_reg;
    logic signed [15:0] center_next, center_reg;
    logic [15:0]        size_next, size_reg;

    always_comb
    begin
        if (d_flg.zero)
            depth_next = '0;
        else if (d_flg.ovf)
            depth_next = d_flg.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (d_flg.neg)
            depth_next = (d_quo > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-d_quo);
        else
            depth_next = d_quo[31] ? 32'sh7FFF_FFFF : d_quo;

        if (c_flg.zero)
            center_next = '0;
        else if (c_flg.ovf)
            center_next = c_flg.neg ? 16'sh8000 : 16'sh7FFF;
        else if (c_flg.neg)
            center_next = (c_quo > 32'd32768) ? 16'sh8000 : 16'(-c_quo);
        else
            center_next = (c_quo > 32'd32767) ? 16'sh7FFF : c_quo[15:0];

        if (s_flg.zero)
            size_next = '0;
        else if (s_flg.ovf || (s_quo > 32'd65535))
            size_next = 16'hFFFF;
        else
            size_next = s_quo[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_F1])
        begin
            depth_reg  <= depth_next;
            center_reg <= center_next;
            size_reg   <= size_next;
        end
    end

    // ------------------------------------------------------------------
    // Draw rectangle and output register
    // ------------------------------------------------------------------
    logic [14:0]        half_s;
    logic signed [16:0] top_w;
    logic [16:0]        bot_w;
    logic signed [17:0] left_w, right_w;
    logic [11:0]        top_next, bot_next, left_next;
    logic [15:0]        right_next;

    assign half_s  = size_reg[15:1];
    assign top_w   = $signed({6'd0, half_h}) - $signed({2'd0, half_s});
    assign bot_w   = {6'd0, half_h} + {2'd0, half_s};
    assign left_w  = {{2{center_reg[15]}}, center_reg} - $signed({3'd0, half_s});
    assign right_w = {{2{center_reg[15]}}, center_reg} + $signed({3'd0, half_s});

    always_comb
    begin
        top_next = top_w[16] ? 12'd0 : top_w[11:0];

        if (bot_w >= {5'd0, scr_h_reg})
            bot_next = (scr_h_reg == '0) ? 12'd0 : scr_h_reg - 12'd1;
        else
            bot_next = bot_w[11:0];

        if (left_w[17])
            left_next = 12'd0;
        else if (left_w > 18'sd4095)
            left_next = 12'd4095;
        else
            left_next = left_w[11:0];

        if (right_w >= $signed({6'd0, scr_w_reg}))
            right_next = {4'd0, scr_w_reg};
        else
            right_next = right_w[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            depth      <= depth_reg;
            in_front   <= (depth_reg > 32'sd0);
            center_col <= center_reg;
            size_px    <= size_reg;
            top_row    <= top_next;
            bottom_row <= bot_next;
            left_col   <= left_next;
            right_col  <= right_next;
        end
    end

endmodule

### verif/sprite_screen_projection_tb.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_tb
// Self-checking bench for the sprite projection pipe. Each sprite transfer is
// projected by a bench-side integer model at full precision and queued; each
// result transfer is compared field by field with the oldest projection.
// Camera and screen registers are rewritten between phases while the pipe is
// empty, covering degenerate matrices, tiny and zero screens and extremes.
// ----------------------------------------------------------------------------
module sprite_screen_projection_tb;

    typedef struct packed {
        logic signed [31:0] depth;
        logic               in_front;
        logic signed [15:0] center_col;
        logic [15:0]        size_px;
        logic [11:0]        top_row;
        logic [11:0]        bottom_row;
        logic [11:0]        left_col;
        logic signed [15:0] right_col;
    } sprite_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] obj_x = '0;
    logic signed [31:0] obj_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] depth;
    logic               in_front;
    logic signed [15:0] center_col;
    logic [15:0]        size_px;
    logic [11:0]        top_row;
    logic [11:0]        bottom_row;
    logic [11:0]        left_col;
    logic signed [15:0] right_col;

    // Bench copy of the camera registers
    logic signed [31:0] cam_x, cam_y;
    logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
    logic [11:0]        scr_w, scr_h;

    sprite_res_t projected_q[$];
    int  mismatches = 0;
    bit  no_idle = 1'b0;
    logic hold_on = 1'b0;
    int  stall_left = 0;

    sprite_screen_projection uut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Truncating quotient saturated to [lo, hi]; zero divisor follows dividend sign
    function automatic logic signed [127:0] quot_sat(logic signed [127:0] num,
            logic signed [127:0] den, logic signed [127:0] lo, logic signed [127:0] hi);
        logic signed [127:0] q;
        if (den == 0)
            return (num > 0) ? hi : ((num < 0) ? lo : 0);
        q = num / den;
        if (q < lo)
            return lo;
        if (q > hi)
            return hi;
        return q;
    endfunction

    function automatic sprite_res_t project_sprite(logic signed [31:0] ox,
            logic signed [31:0] oy);
        logic signed [127:0] dx, dy, cx, cy, dxv, dyv, px, py, w, h;
        logic signed [127:0] det, tx, ty, dep, ctr, adet, aty, sz, hs;
        logic signed [127:0] top, bot, lft, rgt;
        sprite_res_t r;
        dx = ox;   cx = cam_x;   dx = dx - cx;
        dy = oy;   cy = cam_y;   dy = dy - cy;
        dxv = dir_x;   dyv = dir_y;   px = plane_x;   py = plane_y;
        w = scr_w;     h = scr_h;
        det = px * dyv - dxv * py;
        tx  = dyv * dx - dxv * dy;
        ty  = px * dy - py * dx;
        dep = quot_sat(ty * 16384, det, -64'sd2147483648, 64'sd2147483647);
        ctr = quot_sat((w >>> 1) * (tx + ty), ty, -32768, 32767);
        adet = (det < 0) ? -det : det;
        aty  = (ty < 0) ? -ty : ty;
        sz  = quot_sat(h * adet * 4, aty, 0, 65535);
        hs  = sz >>> 1;
        top = (h >>> 1) - hs;
        bot = (h >>> 1) + hs;
        lft = ctr - hs;
        rgt = ctr + hs;
        if (top < 0)
            top = 0;
        if (bot >= h)
            bot = (h == 0) ? 0 : h - 1;
        if (lft < 0)
            lft = 0;
        if (lft > 4095)
            lft = 4095;
        if (rgt >= w)
            rgt = w;
        r.depth      = dep[31:0];
        r.in_front   = dep > 0;
        r.center_col = ctr[15:0];
        r.size_px    = sz[15:0];
        r.top_row    = top[11:0];
        r.bottom_row = bot[11:0];
        r.left_col   = lft[11:0];
        r.right_col  = rgt[15:0];
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side stall
    always @(posedge clk)
    begin
        if (hold_on)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            int g;
            g = gap_len();
            out_stall  <= (g > 0);
            stall_left <= (g > 0) ? g - 1 : 0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sprite_res_t got, want;
            got = '{depth, in_front, center_col, size_px, top_row, bottom_row,
                    left_col, right_col};
            if (projected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
            end
            else
            begin
                want = projected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch:\n  exp %p\n  got %p", want, got);
                end
            end
        end
    end

    // One sprite transfer; returns just after the accepting edge or the gap
    task automatic send_sprite(logic signed [31:0] x, logic signed [31:0] y);
        int g;
        in_valid <= 1'b1;
        obj_x    <= x;
        obj_y    <= y;
        projected_q.push_back(project_sprite(x, y));
        do
            @(posedge clk);
        while (in_stall);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (projected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Whole register set, written while the pipe is empty
    task automatic set_camera(logic signed [31:0] cx, logic signed [31:0] cy,
            logic signed [15:0] dx, logic signed [15:0] dy, logic signed [15:0] px,
            logic signed [15:0] py, logic [11:0] w, logic [11:0] h);
        write_reg(ssp_pkg::REG_CAM_POS_X, cx);
        write_reg(ssp_pkg::REG_CAM_POS_Y, cy);
        write_reg(ssp_pkg::REG_VIEW_DIR_X, {{16{dx[15]}}, dx});
        write_reg(ssp_pkg::REG_VIEW_DIR_Y, {{16{dy[15]}}, dy});
        write_reg(ssp_pkg::REG_VIEW_PLANE_X, {{16{px[15]}}, px});
        write_reg(ssp_pkg::REG_VIEW_PLANE_Y, {{16{py[15]}}, py});
        write_reg(ssp_pkg::REG_SCREEN_W, {20'd0, w});
        write_reg(ssp_pkg::REG_SCREEN_H, {20'd0, h});
        cfg_we <= 1'b0;
        cam_x = cx;  cam_y = cy;  dir_x = dx;  dir_y = dy;
        plane_x = px;  plane_y = py;  scr_w = w;  scr_h = h;
        repeat (5) @(posedge clk);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] c);
        return c + $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    endfunction

    function automatic logic signed [31:0] pick_pos(logic signed [31:0] c);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return near(c);
        if (r < 8)
            return $urandom;
        return (r == 8) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    function automatic logic signed [15:0] pick_vec();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        if (r < 9)
            return 16'($urandom);
        return (r == 9 && $urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
    endfunction

    function automatic logic [11:0] pick_res();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 12'd1;
        if (r == 1)
            return 12'd4095;
        return 12'($urandom_range(1, 4095));
    endfunction

    task automatic test_directed();
        set_camera(0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 12'd640, 12'd480);
        send_sprite(32'sh0001_0000, 0);
        send_sprite(32'sh0003_8000, 32'sh0000_8000);
        send_sprite(-32'sh0002_0000, 32'sh0001_0000);     // behind camera
        send_sprite(0, 0);                               // sprite on camera
        send_sprite(0, 32'sh0001_0000);                  // zero depth
        send_sprite(32'sh0000_0001, 32'sh0000_0010);     // tiny depth, huge size
        send_sprite(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_sprite(32'sh8000_0000, 32'sh8000_0000);
        send_sprite(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sprite(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sprite(32'sh0001_0000, 32'sh7FFF_0000);     // far off to one side
        drain();
        // Camera at the far corner, extreme vectors
        set_camera(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh7FFF,
                   16'sh7FFF, 16'sh8000, 12'd4095, 12'd4095);
        send_sprite(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sprite(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sprite(0, 0);
        drain();
    endtask

    task automatic test_zero_det();
        set_camera(0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd10813, 12'd640, 12'd480);
        send_sprite(32'sh0002_0000, 32'sh0001_0000);
        send_sprite(0, 0);
        send_sprite(-32'sh0002_0000, 32'sh0001_0000);
        drain();
        set_camera(32'sh0001_0000, 0, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                   12'd640, 12'd480);
        send_sprite(32'sh0004_0000, 32'sh0002_0000);
        send_sprite(32'sh0001_0000, 0);
        send_sprite(0, 32'sh0003_0000);
        drain();
    endtask

    task automatic test_tiny_screens();
        set_camera(0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 12'd1, 12'd1);
        repeat (5) send_sprite(pick_pos(0), pick_pos(0));
        drain();
        set_camera(0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 12'd0, 12'd0);
        send_sprite(32'sh0002_0000, 0);
        send_sprite(32'sh0000_4000, 32'sh0000_1000);
        repeat (3) send_sprite(pick_pos(0), pick_pos(0));
        drain();
    endtask

    task automatic test_random_views();
        logic signed [31:0] cx, cy;
        for (int ph = 0; ph < 12; ph++)
        begin
            cx = ($urandom_range(0, 3) == 0) ? $urandom : near(0);
            cy = ($urandom_range(0, 3) == 0) ? $urandom : near(0);
            set_camera(cx, cy, pick_vec(), pick_vec(), pick_vec(), pick_vec(),
                       pick_res(), pick_res());
            no_idle = (ph % 4 == 3);
            repeat (95) send_sprite(pick_pos(cx), pick_pos(cy));
            drain();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_camera(0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 12'd640, 12'd480);
        no_idle = 1'b1;
        fork
            begin
                hold_on <= 1'b1;
                repeat (300) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        repeat (100) send_sprite(near(0), near(0));
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_zero_det();
        test_tiny_screens();
        test_random_views();
        test_backpressure();
        if (mismatches == 0 && projected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
